FILE: hdl/fpba_pkg.sv
// ----------------------------------------------------------------------------
// Fit-policy block allocator package
// Shared constants, codes and the sequencer state type.
// ----------------------------------------------------------------------------
package fpba_pkg;

   localparam int NUM_BLOCKS_DEF = 16;
   localparam int SIZE_BITS_DEF  = 16;

   // fixed port widths
   localparam int CMD_W     = 1;
   localparam int INDEX_W   = 4;
   localparam int AMOUNT_W  = 16;
   localparam int STATUS_W  = 2;
   localparam int LEFT_W    = 16;
   localparam int POLICY_W  = 2;
   localparam int COUNT_W   = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 5;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_LOADED    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT    = 2'd2;

   localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 2'd1;

   localparam logic [POLICY_W-1:0] POLICY_RESET = POLICY_FIRST;
   localparam logic [COUNT_W-1:0]  COUNT_RESET  = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_DONE
   } fpba_state_type;

endpackage

FILE: hdl/fit_policy_block_allocator_core.sv
// ----------------------------------------------------------------------------
// Fit-policy block allocator core
// Holds free space per block and serves load and allocate words with
// first, best or worst fit, scanning the table through one comparator.
// ----------------------------------------------------------------------------
// Load word: accepted in idle, then the done state, then back to idle.
// Allocate word: the scan walks up to min(block_count, NUM_BLOCKS) blocks
// through the single RAM read port, one block a cycle; first fit
// ends the scan at the first fitting block.
// Result passes from write-back via the done state; it is held while stalled.
// Reset clears the valid flags at once, so every block reads as zero space.
module fit_policy_block_allocator_core
   import fpba_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
   parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [INDEX_W-1:0]   req_block_index,
   input  logic [AMOUNT_W-1:0]  req_amount,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [INDEX_W-1:0]   rsp_chosen_block,
   output logic [LEFT_W-1:0]    rsp_space_left,
   // configuration
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   localparam int IDX_W  = $clog2(NUM_BLOCKS);
   localparam int CLOG_N = $clog2(NUM_BLOCKS + 1);
   localparam int LIM_W  = (CLOG_N > COUNT_W) ? CLOG_N : COUNT_W;

   fpba_state_type state_ff, state_in;

   logic [POLICY_W-1:0]   policy_ff, policy_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [NUM_BLOCKS-1:0] valid_ff, valid_in;

   logic [SIZE_BITS-1:0]  amt_ff, amt_in;
   logic [LIM_W-1:0]      limit_ff, limit_in;
   logic [LIM_W-1:0]      issue_ff, issue_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  rd_ok_ff, rd_ok_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      pick_ff, pick_in;
   logic [SIZE_BITS-1:0]  best_ff, best_in;

   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [INDEX_W-1:0]    res_blk_ff, res_blk_in;
   logic [LEFT_W-1:0]     res_left_ff, res_left_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]    rsp_blk_ff, rsp_blk_in;
   logic [LEFT_W-1:0]     rsp_left_ff, rsp_left_in;

   logic                  req_take;
   logic                  csr_take;
   logic                  load_ok;
   logic [SIZE_BITS-1:0]  req_size;
   logic [LIM_W-1:0]      req_limit;
   logic                  is_first;
   logic                  issuing;
   logic                  fits;
   logic                  stop;
   logic                  out_free;
   logic [SIZE_BITS-1:0]  rd_data;
   logic [SIZE_BITS-1:0]  cur_space;
   logic [SIZE_BITS-1:0]  diff;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [SIZE_BITS-1:0]  wr_data;
   logic [IDX_W-1:0]      rd_addr;

   fpba_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (NUM_BLOCKS)
   ) u_space_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign load_ok   = (32'(req_block_index) < 32'(NUM_BLOCKS));
   assign req_size  = SIZE_BITS'(req_amount);
   assign req_limit = (LIM_W'(count_ff) > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS)
                                                               : LIM_W'(count_ff);
   assign is_first  = !(policy_ff == POLICY_BEST || policy_ff == POLICY_WORST);
   assign issuing   = (issue_ff != limit_ff);
   assign rd_addr   = issue_ff[IDX_W-1:0];
   assign cur_space = rd_ok_ff ? rd_data : '0;
   assign fits      = (cur_space >= amt_ff);
   assign diff      = best_ff - amt_ff;

   // configuration registers
   always_comb begin
      policy_in = policy_ff;
      count_in  = count_ff;
      if (csr_take) begin
         unique case (csr_index)
            CSR_FIT_POLICY: begin
               policy_in = csr_data[POLICY_W-1:0];
            end
            CSR_BLOCK_COUNT: begin
               count_in = csr_data[COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      amt_in        = amt_ff;
      limit_in      = limit_ff;
      issue_in      = issue_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_addr;
      rd_ok_in      = valid_ff[rd_addr];
      found_in      = found_ff;
      pick_in       = pick_ff;
      best_in       = best_ff;
      res_status_in = res_status_ff;
      res_blk_in    = res_blk_ff;
      res_left_in   = res_left_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_blk_in    = rsp_blk_ff;
      rsp_left_in   = rsp_left_ff;
      wr_en         = 1'b0;
      wr_addr       = pick_ff;
      wr_data       = diff;
      valid_in      = valid_ff;
      stop          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_cmd == CMD_LOAD) begin
                  wr_en         = load_ok;
                  wr_addr       = IDX_W'(req_block_index);
                  wr_data       = req_size;
                  res_status_in = STATUS_LOADED;
                  res_blk_in    = req_block_index;
                  res_left_in   = load_ok ? LEFT_W'(req_size) : '0;
                  state_in      = ST_DONE;
               end else begin
                  amt_in   = req_size;
                  limit_in = req_limit;
                  issue_in = '0;
                  found_in = 1'b0;
                  // nothing to scan: report no fit straight away
                  if (req_limit == '0) begin
                     res_status_in = STATUS_NO_FIT;
                     res_blk_in    = '0;
                     res_left_in   = '0;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (rd_vld_ff && fits) begin
               if (!found_ff) begin
                  found_in = 1'b1;
                  pick_in  = rd_idx_ff;
                  best_in  = cur_space;
                  stop     = is_first;
               end else if ((policy_ff == POLICY_BEST && cur_space < best_ff) ||
                            (policy_ff == POLICY_WORST && cur_space > best_ff)) begin
                  pick_in = rd_idx_ff;
                  best_in = cur_space;
               end
            end
            if (stop || !issuing) begin
               state_in = ST_WRITE;
            end else begin
               rd_vld_in = 1'b1;
               issue_in  = issue_ff + LIM_W'(1);
            end
         end
         ST_WRITE: begin
            if (found_ff) begin
               wr_en         = 1'b1;
               res_status_in = STATUS_ALLOCATED;
               res_blk_in    = INDEX_W'(pick_ff);
               res_left_in   = LEFT_W'(diff);
            end else begin
               res_status_in = STATUS_NO_FIT;
               res_blk_in    = '0;
               res_left_in   = '0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_blk_in    = res_blk_ff;
               rsp_left_in   = res_left_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= POLICY_RESET;
         count_ff     <= COUNT_RESET;
         valid_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      amt_ff        <= amt_in;
      limit_ff      <= limit_in;
      issue_ff      <= issue_in;
      rd_idx_ff     <= rd_idx_in;
      rd_ok_ff      <= rd_ok_in;
      found_ff      <= found_in;
      pick_ff       <= pick_in;
      best_ff       <= best_in;
      res_status_ff <= res_status_in;
      res_blk_ff    <= res_blk_in;
      res_left_ff   <= res_left_in;
      rsp_status_ff <= rsp_status_in;
      rsp_blk_ff    <= rsp_blk_in;
      rsp_left_ff   <= rsp_left_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_chosen_block = rsp_blk_ff;
   assign rsp_space_left   = rsp_left_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (issue_ff <= limit_ff))
      else $error("scan counter ran past the block limit");

   a_pick_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && found_ff) |-> (best_ff >= amt_ff))
      else $error("chosen block smaller than the request");

   a_write_window: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_IDLE || state_ff == ST_WRITE))
      else $error("table written during a scan");

endmodule

FILE: hdl/fpba_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fpba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
